FILE: sv/ewl_pkg.sv
// Package for the wear-leveling ring: types, codes and constants.
package ewl_pkg;

	localparam int RING_DEPTH_DEF = 16;
	localparam logic [7:0] ERASED = 8'hFF;
	localparam logic [4:0] RING_SIZE_RST = 5'd16;
	localparam logic REG_RING_SIZE = 1'b0;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_FIND = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_in;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] pointer_index;
		logic       data_written;
	} rsp_item_t;

	typedef struct packed {
		logic [8:0] sum;
		logic       eq;
		logic       ge;
	} unit_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_W_RD,
		S_W_UPD,
		S_W_NXT,
		S_R_RD,
		S_R_DAT,
		S_F_START,
		S_F_LOAD,
		S_F_CHK,
		S_F_CMP,
		S_DONE
	} state_t;

endpackage

FILE: sv/ewl_ram.sv
// Byte store with per-entry valid bits; unwritten entries read as erased.
module ewl_ram import ewl_pkg::*; #(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int AW = $clog2(RING_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_q;
	logic             rv_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rv_q <= valid_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : ERASED;

endmodule

FILE: sv/ewl_unit.sv
// Shared increment and compare unit: a+1, equality with b, a+1 >= lim.
module ewl_unit import ewl_pkg::*; (
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [4:0] lim,
	output unit_res_t  res
);

	logic [8:0] sum;

	assign sum = {1'b0, a} + 9'd1;
	assign res.sum = sum;
	assign res.eq = (sum[7:0] == b);
	assign res.ge = (sum >= {4'b0, lim});

endmodule

FILE: sv/eeprom_wear_level_ring_unit.sv
// Top level of the wear-leveling ring: sequencer, stores and config port.
//
// Usage: commands enter on cmd (mode, data_in) under cmd_valid/cmd_stall and
// one response leaves on rsp (read_data, pointer_index, data_written) under
// rsp_valid/rsp_stall for every command. A transaction completes at a clock
// edge with valid high and stall low. The ring_size register (APB, address 0)
// sets the slots in use; the user must write it only while no command is in
// flight, as the block itself does not enforce this. All work runs through
// one increment/compare unit and one read port per store, so one command is
// in flight at a time; cmd_stall is high until its response has been moved
// into the output register, so the next command is taken only after that.
// A new command may be taken while that response waits on rsp_stall; the
// next response holds until it is taken. Reset clears the pointer, sets
// ring_size to 16 and marks both stores erased (0xFF) at once through their
// valid bits.
module eeprom_wear_level_ring_unit import ewl_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp
);

	localparam int PW = $clog2(RING_DEPTH);

	state_t      state_q, state_d;
	logic [4:0]  ring_size_q;
	logic [4:0]  n_used;
	logic [7:0]  byte_q;
	logic [PW-1:0] ptr_q, scan_q, prev_slot, next_ptr, raddr;
	logic [7:0]  cur_q, st_q;
	rsp_item_t   res_q, out_q;
	logic        out_valid_q;
	logic        cmd_acc, out_load;
	logic [7:0]  unit_a, unit_b;
	unit_res_t   ures;
	logic [7:0]  data_rd, stat_rd;
	logic        data_we, stat_we;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RING_SIZE) ? {27'b0, ring_size_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= RING_SIZE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_RING_SIZE) begin
			ring_size_q <= pwdata[4:0];
		end
	end

	always_comb begin
		if (ring_size_q == 5'd0) begin
			n_used = 5'd1;
		end else if (32'(ring_size_q) > RING_DEPTH) begin
			n_used = 5'(RING_DEPTH);
		end else begin
			n_used = ring_size_q;
		end
	end

	assign prev_slot = (ptr_q == '0) ? PW'(n_used - 5'd1) : ptr_q - PW'(1);
	assign next_ptr = ures.ge ? '0 : ures.sum[PW-1:0];

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !rsp_stall);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	ewl_unit u_unit (
		.a   (unit_a),
		.b   (unit_b),
		.lim (n_used),
		.res (ures)
	);

	ewl_ram #(.DEPTH(RING_DEPTH), .AW(PW)) u_data (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (data_we),
		.waddr  (ptr_q),
		.wdata  (byte_q),
		.raddr  (raddr),
		.rdata  (data_rd)
	);

	ewl_ram #(.DEPTH(RING_DEPTH), .AW(PW)) u_status (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (stat_we),
		.waddr  (next_ptr),
		.wdata  (st_q),
		.raddr  (raddr),
		.rdata  (stat_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.mode)
						MODE_WRITE: state_d = S_W_RD;
						MODE_READ:  state_d = S_R_RD;
						MODE_FIND:  state_d = S_F_START;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_W_RD:    state_d = S_W_UPD;
			S_W_UPD:   state_d = S_W_NXT;
			S_W_NXT:   state_d = S_DONE;
			S_R_RD:    state_d = S_R_DAT;
			S_R_DAT:   state_d = S_DONE;
			S_F_START: state_d = S_F_LOAD;
			S_F_LOAD:  state_d = S_F_CHK;
			S_F_CHK:   state_d = ures.ge ? S_DONE : S_F_CMP;
			S_F_CMP:   state_d = ures.eq ? S_F_CHK : S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		unit_a = 8'd0;
		unit_b = stat_rd;
		raddr = ptr_q;
		data_we = 1'b0;
		stat_we = 1'b0;
		case (state_q)
			S_W_UPD: begin
				unit_a = stat_rd;
				data_we = (data_rd != byte_q);
			end
			S_W_NXT: begin
				unit_a = 8'(ptr_q);
				stat_we = 1'b1;
			end
			S_R_RD:    raddr = prev_slot;
			S_F_START: raddr = '0;
			S_F_CHK: begin
				unit_a = 8'(scan_q);
				raddr = ures.sum[PW-1:0];
			end
			S_F_CMP:   unit_a = cur_q;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_W_NXT) begin
				ptr_q <= next_ptr;
			end else if ((state_q == S_F_CHK && ures.ge) ||
					(state_q == S_F_CMP && !ures.eq)) begin
				ptr_q <= scan_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					byte_q <= cmd.data_in;
					res_q <= '{read_data: 8'd0, pointer_index: 4'(ptr_q),
						data_written: 1'b0};
				end
			end
			S_W_UPD: begin
				st_q <= ures.sum[7:0];
				res_q.data_written <= (data_rd != byte_q);
			end
			S_W_NXT:   res_q.pointer_index <= 4'(next_ptr);
			S_R_DAT:   res_q.read_data <= data_rd;
			S_F_START: scan_q <= '0;
			S_F_LOAD:  cur_q <= stat_rd;
			S_F_CHK: begin
				if (ures.ge) begin
					res_q.pointer_index <= 4'(scan_q);
				end
			end
			S_F_CMP: begin
				if (ures.eq) begin
					scan_q <= scan_q + PW'(1);
					cur_q <= stat_rd;
				end else begin
					res_q.pointer_index <= 4'(scan_q);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/sv/tb_eeprom_wear_level_ring_unit.sv
// Testbench for eeprom_wear_level_ring_unit: directed table, then random phases per ring size.
`timescale 1ns / 100ps

module tb_eeprom_wear_level_ring_unit;
	import ewl_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_RING_SIZE = {REG_RING_SIZE, 2'b00};
	localparam int SETTLE = 2 * RING_DEPTH_DEF + 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_ROWS = 26;
	localparam int N_PHASE_ITEMS = 95;

	typedef struct packed {
		cmd_item_t  c;
		logic       fixed_on;
		rsp_item_t  fixed;
	} ring_row_t;

	typedef struct {
		rsp_item_t  pred;
		logic       fixed_on;
		rsp_item_t  fixed;
	} ring_due_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_item_t   cmd = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp;

	logic        fixed_on = 1'b0;
	rsp_item_t   fixed_rsp = '0;

	logic [7:0]  status_ring [RING_DEPTH_DEF];
	logic [7:0]  data_ring [RING_DEPTH_DEF];
	logic [3:0]  ring_ptr = '0;
	logic [4:0]  ring_size_cfg = RING_SIZE_RST;

	ring_due_t   ring_rsp_due [$];
	ring_row_t   dir_rows [N_ROWS];
	int          fail_cnt = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          stall_cnt = 0;

	eeprom_wear_level_ring_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	task automatic ring_step_predict(input cmd_item_t c, output rsp_item_t r);
		int n;
		int p;
		int slot;
		logic [7:0] st;
		n = (ring_size_cfg == 0) ? 1 : int'(ring_size_cfg);
		if (n > RING_DEPTH_DEF) n = RING_DEPTH_DEF;
		p = int'(ring_ptr);
		r = '0;
		case (c.mode)
			MODE_WRITE: begin
				if (data_ring[p] != c.data_in) begin
					data_ring[p] = c.data_in;
					r.data_written = 1'b1;
				end
				st = status_ring[p] + 8'd1;
				p = (p + 1 >= n) ? 0 : p + 1;
				status_ring[p] = st;
			end
			MODE_READ: begin
				slot = (p == 0) ? n - 1 : p - 1;
				r.read_data = data_ring[slot];
			end
			MODE_FIND: begin
				p = 0;
				while (p + 1 < n && status_ring[p + 1] == 8'(status_ring[p] + 8'd1))
					p++;
			end
			default: ;
		endcase
		ring_ptr = 4'(p);
		r.pointer_index = 4'(p);
	endtask

	task automatic check_rsp(string src, rsp_item_t e, rsp_item_t a);
		if (a.read_data !== e.read_data) begin
			$error("%s read_data expected %0h got %0h", src, e.read_data, a.read_data);
			fail_cnt++;
		end
		if (a.pointer_index !== e.pointer_index) begin
			$error("%s pointer_index expected %0d got %0d", src, e.pointer_index,
				a.pointer_index);
			fail_cnt++;
		end
		if (a.data_written !== e.data_written) begin
			$error("%s data_written expected %0b got %0b", src, e.data_written,
				a.data_written);
			fail_cnt++;
		end
	endtask

	function automatic ring_row_t mk_row(logic [1:0] m, logic [7:0] d, logic fon,
		logic [7:0] rd, logic [3:0] ptr, logic dw);
		ring_row_t row;
		row.c.mode = m;
		row.c.data_in = d;
		row.fixed_on = fon;
		row.fixed.read_data = rd;
		row.fixed.pointer_index = ptr;
		row.fixed.data_written = dw;
		return row;
	endfunction

	function automatic cmd_item_t ring_random_cmd();
		cmd_item_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.data_in = 8'($urandom);
		if (pick < 60) begin
			c.mode = MODE_WRITE;
			if ($urandom_range(0, 3) == 0) c.data_in = data_ring[ring_ptr];
		end else if (pick < 80) begin
			c.mode = MODE_READ;
		end else if (pick < 95) begin
			c.mode = MODE_FIND;
		end else begin
			c.mode = MODE_UNUSED;
		end
		return c;
	endfunction

	task automatic drive_item(cmd_item_t c, logic fon, rsp_item_t fx);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		fixed_on <= fon;
		fixed_rsp <= fx;
		do @(posedge clk); while (cmd_stall !== 1'b0);
	endtask

	task automatic drain_rsp();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (ring_rsp_due.size() != 0);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ring_size_cfg = val[4:0];
	endtask

	// transaction monitor and scoreboard
	always @(posedge clk) begin
		rsp_item_t pr;
		ring_due_t due;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				ring_step_predict(cmd, pr);
				due.pred = pr;
				due.fixed_on = fixed_on;
				due.fixed = fixed_rsp;
				ring_rsp_due.push_back(due);
				moved = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (ring_rsp_due.size() == 0) begin
					$error("unexpected response %p", rsp);
					fail_cnt++;
				end else begin
					due = ring_rsp_due.pop_front();
					check_rsp("model", due.pred, rsp);
					if (due.fixed_on) check_rsp("table", due.fixed, rsp);
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// response stall pattern
	always @(posedge clk) begin
		if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
		end else begin
			rsp_stall <= ~rsp_stall;
			stall_cnt <= rsp_stall ? $urandom_range(0, 40) : $urandom_range(0, 6);
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int cfg_plan [10];
		int i;
		int k;
		for (i = 0; i < RING_DEPTH_DEF; i++) begin
			status_ring[i] = ERASED;
			data_ring[i] = ERASED;
		end
		cfg_plan = '{1, 0, 31, 17, 2, 3, 8, 16, 15, 5};
		cfg_plan[9] = $urandom_range(1, 16);

		dir_rows[0]  = mk_row(MODE_READ,   8'hFF, 1'b1, 8'hFF, 4'd0, 1'b0);
		dir_rows[1]  = mk_row(MODE_FIND,   8'h00, 1'b1, 8'h00, 4'd0, 1'b0);
		dir_rows[2]  = mk_row(MODE_UNUSED, 8'hFF, 1'b1, 8'h00, 4'd0, 1'b0);
		dir_rows[3]  = mk_row(MODE_WRITE,  8'hFF, 1'b1, 8'h00, 4'd1, 1'b0);
		dir_rows[4]  = mk_row(MODE_WRITE,  8'h00, 1'b1, 8'h00, 4'd2, 1'b1);
		dir_rows[5]  = mk_row(MODE_READ,   8'hA5, 1'b1, 8'h00, 4'd2, 1'b0);
		dir_rows[6]  = mk_row(MODE_WRITE,  8'h80, 1'b1, 8'h00, 4'd3, 1'b1);
		dir_rows[7]  = mk_row(MODE_UNUSED, 8'h00, 1'b1, 8'h00, 4'd3, 1'b0);
		dir_rows[8]  = mk_row(MODE_FIND,   8'hFF, 1'b1, 8'h00, 4'd3, 1'b0);
		for (i = 9; i < 22; i++)
			dir_rows[i] = mk_row(MODE_WRITE, 8'(i * 37 + 1), 1'b0, '0, '0, 1'b0);
		dir_rows[22] = mk_row(MODE_FIND,   8'h00, 1'b0, '0, '0, 1'b0);
		dir_rows[23] = mk_row(MODE_WRITE,  8'h7F, 1'b0, '0, '0, 1'b0);
		dir_rows[24] = mk_row(MODE_FIND,   8'h00, 1'b0, '0, '0, 1'b0);
		dir_rows[25] = mk_row(MODE_READ,   8'h00, 1'b0, '0, '0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++)
			drive_item(dir_rows[i].c, dir_rows[i].fixed_on, dir_rows[i].fixed);
		drain_rsp();
		repeat (SETTLE) @(posedge clk);

		for (i = 0; i < 10; i++) begin
			apb_write(ADDR_RING_SIZE, 32'(cfg_plan[i]));
			for (k = 0; k < N_PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) == 0) begin
					drain_rsp();
					burst_left = 0;
				end
				drive_item(ring_random_cmd(), 1'b0, '0);
			end
			drain_rsp();
			repeat (SETTLE) @(posedge clk);
		end

		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
